### rtl/dsu_pkg.sv
// Shared types and constants of the disjoint-set union-find engine.
`default_nettype none
package dsu_pkg;

  localparam int MAX_ELEMENTS = 1024;
  localparam int IDX_W        = $clog2(MAX_ELEMENTS);
  localparam int CNT_W        = IDX_W + 1;
  localparam int ENT_W        = CNT_W + 1;

  typedef enum logic [1:0] {
    MODE_UNITE = 2'd0,
    MODE_SAME  = 2'd1,
    MODE_SIZE  = 2'd2,
    MODE_COUNT = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_COMP,
    ST_FINISH,
    ST_LINK,
    ST_RESP
  } state_t;

  typedef struct packed {
    mode_t            mode;
    logic [IDX_W-1:0] elem_x;
    logic [IDX_W-1:0] elem_y;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0] root_x;
    logic             merged;
    logic             in_same_set;
    logic [CNT_W-1:0] set_size;
    logic [CNT_W-1:0] component_count;
    logic             index_error;
  } out_item_t;

  typedef struct packed {
    logic             load;
    logic [CNT_W-1:0] count;
  } cfg_ctl_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [ENT_W-1:0] wdata;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

endpackage
`default_nettype wire

### rtl/disjoint_set_union_find.sv
// Top level of the disjoint-set union-find engine: config register, result stage.
//
//  channel   ports                         handshake        payload
//  -------   ----------------------------  ---------------  ----------------------
//  input     in_valid  in_ready  in_data   valid/ready      mode, elem_x, elem_y
//  result    out_valid out_ready out_data  valid/ready      root_x .. index_error
//  config    cfg_we    cfg_wdata           write enable     element_count
//
//  Count and bad-index requests go straight from acceptance to the hand-off state.
//  A find reads one entry per cycle up to the root, then rewrites each node below
//  the root on that path, one per cycle; unite and same-set add a find for y. Then
//  a finish state, a link state on a merge, and the hand-off state, which loads the
//  output register when it has room; a new request is taken while a result waits
//  there. Reset and every element_count write sweep all 1024 entries, in_ready low.
`default_nettype none
module disjoint_set_union_find (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire dsu_pkg::in_item_t          in_data,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output dsu_pkg::out_item_t              out_data,
  input  wire logic                       cfg_we,
  input  wire logic [dsu_pkg::CNT_W-1:0]  cfg_wdata
);

  logic [dsu_pkg::CNT_W-1:0] elem_count_r;
  logic [dsu_pkg::CNT_W-1:0] cfg_clamped;
  dsu_pkg::cfg_ctl_t         cfg_ctl;
  logic                      res_valid;
  logic                      res_ready;
  dsu_pkg::out_item_t        res;
  dsu_pkg::mem_req_t         mem_req;
  logic [dsu_pkg::ENT_W-1:0] mem_rdata;
  logic                      out_valid_r;
  dsu_pkg::out_item_t        out_data_r;

  always_comb begin
    if (cfg_wdata == '0) begin
      cfg_clamped = dsu_pkg::CNT_W'(1);
    end else if (cfg_wdata > dsu_pkg::CNT_W'(dsu_pkg::MAX_ELEMENTS)) begin
      cfg_clamped = dsu_pkg::CNT_W'(dsu_pkg::MAX_ELEMENTS);
    end else begin
      cfg_clamped = cfg_wdata;
    end
    cfg_ctl.load  = cfg_we;
    cfg_ctl.count = cfg_clamped;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elem_count_r <= dsu_pkg::CNT_W'(dsu_pkg::MAX_ELEMENTS);
    end else if (cfg_we) begin
      elem_count_r <= cfg_clamped;
    end
  end

  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  dsu_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_ctl),
    .elem_count (elem_count_r),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res),
    .mem        (mem_req),
    .mem_rdata  (mem_rdata)
  );

  dsu_ram #(
    .DEPTH (dsu_pkg::MAX_ELEMENTS),
    .WIDTH (dsu_pkg::ENT_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .raddr (mem_req.raddr),
    .rdata (mem_rdata)
  );

endmodule
`default_nettype wire

### rtl/dsu_ram.sv
// Simple dual-port table memory with registered read and write-to-read bypass.
`default_nettype none
module dsu_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 12
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // forward a same-cycle write so the reader sees the new entry
  always_ff @(posedge clk) begin
    if (we && (waddr == raddr)) begin
      rdata <= wdata;
    end else begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

### rtl/dsu_ctrl.sv
// Sequencer: table clear, root walk, path compression, union and result build.
`default_nettype none
module dsu_ctrl (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire dsu_pkg::cfg_ctl_t            cfg,
  input  wire logic [dsu_pkg::CNT_W-1:0]    elem_count,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire dsu_pkg::in_item_t            in_data,
  output logic                              res_valid,
  input  wire logic                         res_ready,
  output dsu_pkg::out_item_t                res,
  output dsu_pkg::mem_req_t                 mem,
  input  wire logic [dsu_pkg::ENT_W-1:0]    mem_rdata
);

  localparam logic [dsu_pkg::IDX_W-1:0] LAST_IDX = dsu_pkg::IDX_W'(dsu_pkg::MAX_ELEMENTS - 1);

  function automatic logic [dsu_pkg::CNT_W-1:0] neg_size(input logic [dsu_pkg::ENT_W-1:0] e);
    logic [dsu_pkg::ENT_W-1:0] n;
    n = -e;
    return n[dsu_pkg::CNT_W-1:0];
  endfunction

  dsu_pkg::state_t              state_r,    state_nxt;
  dsu_pkg::mode_t               mode_r,     mode_nxt;
  logic [dsu_pkg::IDX_W-1:0]    x_r,        x_nxt;
  logic [dsu_pkg::IDX_W-1:0]    y_r,        y_nxt;
  logic [dsu_pkg::IDX_W-1:0]    cur_r,      cur_nxt;
  logic                         pass_r,     pass_nxt;
  logic [dsu_pkg::IDX_W-1:0]    root_x_r,   root_x_nxt;
  logic [dsu_pkg::IDX_W-1:0]    root_y_r,   root_y_nxt;
  logic signed [dsu_pkg::ENT_W-1:0] ent_x_r, ent_x_nxt;
  logic signed [dsu_pkg::ENT_W-1:0] ent_y_r, ent_y_nxt;
  logic [dsu_pkg::IDX_W-1:0]    child_r,    child_nxt;
  logic [dsu_pkg::CNT_W-1:0]    sets_r,     sets_nxt;
  logic [dsu_pkg::IDX_W-1:0]    clr_cnt_r,  clr_cnt_nxt;
  dsu_pkg::out_item_t           res_r,      res_nxt;

  logic [dsu_pkg::IDX_W-1:0]    root_cur;
  logic [dsu_pkg::IDX_W-1:0]    start_idx;
  logic [dsu_pkg::IDX_W-1:0]    parent;
  logic                         pass_done;
  logic                         idx_err;
  logic signed [dsu_pkg::ENT_W-1:0] ent_sum;
  logic                         y_bigger;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= dsu_pkg::ST_CLEAR;
      clr_cnt_r <= '0;
      sets_r    <= dsu_pkg::CNT_W'(dsu_pkg::MAX_ELEMENTS);
      pass_r    <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      sets_r    <= sets_nxt;
      pass_r    <= pass_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r   <= mode_nxt;
    x_r      <= x_nxt;
    y_r      <= y_nxt;
    cur_r    <= cur_nxt;
    root_x_r <= root_x_nxt;
    root_y_r <= root_y_nxt;
    ent_x_r  <= ent_x_nxt;
    ent_y_r  <= ent_y_nxt;
    child_r  <= child_nxt;
    res_r    <= res_nxt;
  end

  always_comb begin
    state_nxt   = state_r;
    mode_nxt    = mode_r;
    x_nxt       = x_r;
    y_nxt       = y_r;
    cur_nxt     = cur_r;
    pass_nxt    = pass_r;
    root_x_nxt  = root_x_r;
    root_y_nxt  = root_y_r;
    ent_x_nxt   = ent_x_r;
    ent_y_nxt   = ent_y_r;
    child_nxt   = child_r;
    sets_nxt    = sets_r;
    clr_cnt_nxt = clr_cnt_r;
    res_nxt     = res_r;

    mem.we    = 1'b0;
    mem.waddr = cur_r;
    mem.wdata = '1;
    mem.raddr = cur_r;

    in_ready  = (state_r == dsu_pkg::ST_IDLE);
    res_valid = (state_r == dsu_pkg::ST_RESP);
    res       = res_r;
    res.component_count = sets_r;

    root_cur  = pass_r ? root_y_r : root_x_r;
    start_idx = pass_r ? y_r : x_r;
    parent    = mem_rdata[dsu_pkg::IDX_W-1:0];
    pass_done = 1'b0;
    idx_err   = (dsu_pkg::CNT_W'(in_data.elem_x) >= elem_count) ||
                ((in_data.mode != dsu_pkg::MODE_SIZE) &&
                 (dsu_pkg::CNT_W'(in_data.elem_y) >= elem_count));
    ent_sum   = ent_x_r + ent_y_r;
    y_bigger  = (ent_y_r < ent_x_r);

    unique case (state_r)
      dsu_pkg::ST_CLEAR: begin
        mem.we    = 1'b1;
        mem.waddr = clr_cnt_r;
        mem.wdata = '1;
        if (clr_cnt_r == LAST_IDX) begin
          state_nxt = dsu_pkg::ST_IDLE;
        end else begin
          clr_cnt_nxt = clr_cnt_r + 1'b1;
        end
      end

      dsu_pkg::ST_IDLE: begin
        if (in_valid) begin
          mode_nxt = in_data.mode;
          x_nxt    = in_data.elem_x;
          y_nxt    = in_data.elem_y;
          pass_nxt = 1'b0;
          if ((in_data.mode == dsu_pkg::MODE_COUNT) || idx_err) begin
            res_nxt             = '0;
            res_nxt.index_error = (in_data.mode != dsu_pkg::MODE_COUNT) && idx_err;
            state_nxt           = dsu_pkg::ST_RESP;
          end else begin
            mem.raddr = in_data.elem_x;
            cur_nxt   = in_data.elem_x;
            state_nxt = dsu_pkg::ST_WALK;
          end
        end
      end

      dsu_pkg::ST_WALK: begin
        if (!mem_rdata[dsu_pkg::ENT_W-1]) begin
          // follow the parent link
          cur_nxt   = parent;
          mem.raddr = parent;
        end else begin
          if (pass_r) begin
            root_y_nxt = cur_r;
            ent_y_nxt  = mem_rdata;
          end else begin
            root_x_nxt = cur_r;
            ent_x_nxt  = mem_rdata;
          end
          if (start_idx != cur_r) begin
            mem.raddr = start_idx;
            cur_nxt   = start_idx;
            state_nxt = dsu_pkg::ST_COMP;
          end else begin
            pass_done = 1'b1;
          end
        end
      end

      dsu_pkg::ST_COMP: begin
        // point the visited node straight at the root, then step on
        mem.we    = 1'b1;
        mem.waddr = cur_r;
        mem.wdata = dsu_pkg::ENT_W'(root_cur);
        if (parent == root_cur) begin
          pass_done = 1'b1;
        end else begin
          cur_nxt   = parent;
          mem.raddr = parent;
        end
      end

      dsu_pkg::ST_FINISH: begin
        res_nxt             = '0;
        res_nxt.root_x      = root_x_r;
        res_nxt.set_size    = neg_size(ent_x_r);
        state_nxt           = dsu_pkg::ST_RESP;
        unique case (mode_r)
          dsu_pkg::MODE_UNITE: begin
            res_nxt.in_same_set = 1'b1;
            if (root_x_r != root_y_r) begin
              mem.we           = 1'b1;
              mem.waddr        = y_bigger ? root_y_r : root_x_r;
              mem.wdata        = ent_sum;
              child_nxt        = y_bigger ? root_x_r : root_y_r;
              res_nxt.root_x   = y_bigger ? root_y_r : root_x_r;
              res_nxt.set_size = neg_size(ent_sum);
              res_nxt.merged   = 1'b1;
              if (sets_r != '0) begin
                sets_nxt = sets_r - 1'b1;
              end
              state_nxt = dsu_pkg::ST_LINK;
            end
          end
          dsu_pkg::MODE_SAME: begin
            res_nxt.in_same_set = (root_x_r == root_y_r);
          end
          dsu_pkg::MODE_SIZE: begin
          end
          dsu_pkg::MODE_COUNT: begin
          end
        endcase
      end

      dsu_pkg::ST_LINK: begin
        mem.we    = 1'b1;
        mem.waddr = child_r;
        mem.wdata = dsu_pkg::ENT_W'(res_r.root_x);
        state_nxt = dsu_pkg::ST_RESP;
      end

      dsu_pkg::ST_RESP: begin
        if (res_ready) begin
          state_nxt = dsu_pkg::ST_IDLE;
        end
      end
    endcase

    if (pass_done) begin
      if (!pass_r && ((mode_r == dsu_pkg::MODE_UNITE) || (mode_r == dsu_pkg::MODE_SAME))) begin
        pass_nxt  = 1'b1;
        mem.raddr = y_r;
        cur_nxt   = y_r;
        state_nxt = dsu_pkg::ST_WALK;
      end else begin
        state_nxt = dsu_pkg::ST_FINISH;
      end
    end

    // a register write restarts the clearing sweep
    if (cfg.load) begin
      state_nxt   = dsu_pkg::ST_CLEAR;
      clr_cnt_nxt = '0;
      sets_nxt    = cfg.count;
    end
  end

endmodule
`default_nettype wire
